### hw/rtl/mpam_pkg.sv
// ----------------------------------------------------------------------------
// mpam_pkg
// Shared field widths, command and status codes for the automaton matcher.
// ----------------------------------------------------------------------------
package mpam_pkg;

   localparam int CMD_W       = 3;
   localparam int LETTER_W    = 5;
   localparam int STATUS_W    = 2;
   localparam int NODE_OUT_W  = 9;
   localparam int MASK_OUT_W  = 8;
   localparam int COUNT_OUT_W = 4;

   localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_END     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_BUILD   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCAN    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TRIE_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PAT_FULL  = 2'd2;

endpackage

### hw/rtl/mpam_req_if.sv
// ----------------------------------------------------------------------------
// mpam_req_if
// Request channel: command and letter with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpam_req_if import mpam_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [LETTER_W-1:0] letter;

   modport source (output valid, output cmd, output letter, input ready);
   modport sink   (input valid, input cmd, input letter, output ready);
endinterface

### hw/rtl/mpam_rsp_if.sv
// ----------------------------------------------------------------------------
// mpam_rsp_if
// Response channel: status, node and match information per request.
// ----------------------------------------------------------------------------
interface mpam_rsp_if import mpam_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [NODE_OUT_W-1:0]  node;
   logic [MASK_OUT_W-1:0]  match_mask;
   logic [COUNT_OUT_W-1:0] new_count;
   logic [MASK_OUT_W-1:0]  seen_mask;

   modport source (output valid, output status, output node, output match_mask,
                   output new_count, output seen_mask, input ready);
   modport sink   (input valid, input status, input node, input match_mask,
                   input new_count, input seen_mask, output ready);
endinterface

### hw/rtl/multi_pattern_automaton_matcher.sv
// Per request: an add that makes a new node also clears that node's child row; a scan
// follows failure hops until a child is found, and on a hit reads the child's output mask.
// Build walks the queued nodes letter by letter; a child under the root links to the root,
// else a failure walk finds its link, and a nonzero link merges that node's output mask in.
// One request in flight at a time; the response register frees the input side.
// Reset (synchronous): a sweep over every letter column clears the root row; req not ready meanwhile.
// ----------------------------------------------------------------------------
// multi_pattern_automaton_matcher
// Aho-Corasick trie loader, breadth-first link builder and scanner built
// around one child table port and a small sequencer.
// ----------------------------------------------------------------------------
module multi_pattern_automaton_matcher import mpam_pkg::*; #(
   parameter int NODES    = 512,
   parameter int ALPHABET = 26,
   parameter int PATTERNS = 8
) (
   input logic         clock,
   input logic         reset,
   mpam_req_if.sink    req_bus,
   mpam_rsp_if.source  rsp_bus
);

   localparam int NW     = $clog2(NODES);
   localparam int CW     = NW + 1;
   localparam int AW     = $clog2(ALPHABET);
   localparam int CDEPTH = NODES * ALPHABET;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int PCW    = $clog2(PATTERNS + 1);

   localparam logic [4:0] ST_CLR     = 5'd0;
   localparam logic [4:0] ST_IDLE    = 5'd1;
   localparam logic [4:0] ST_ADD_RD  = 5'd2;
   localparam logic [4:0] ST_ADD_CHK = 5'd3;
   localparam logic [4:0] ST_S_RD    = 5'd4;
   localparam logic [4:0] ST_S_CHK   = 5'd5;
   localparam logic [4:0] ST_S_FAIL  = 5'd6;
   localparam logic [4:0] ST_S_OUT   = 5'd7;
   localparam logic [4:0] ST_B_POP   = 5'd8;
   localparam logic [4:0] ST_B_U     = 5'd9;
   localparam logic [4:0] ST_B_C_RD  = 5'd10;
   localparam logic [4:0] ST_B_C_CHK = 5'd11;
   localparam logic [4:0] ST_B_D     = 5'd12;
   localparam logic [4:0] ST_B_W_RD  = 5'd13;
   localparam logic [4:0] ST_B_W_CHK = 5'd14;
   localparam logic [4:0] ST_B_WF    = 5'd15;
   localparam logic [4:0] ST_B_SET   = 5'd16;
   localparam logic [4:0] ST_B_M2    = 5'd17;
   localparam logic [4:0] ST_B_M3    = 5'd18;
   localparam logic [4:0] ST_B_NEXT  = 5'd19;
   localparam logic [4:0] ST_DONE    = 5'd20;

   // memories
   logic [NW-1:0]       child_mem [CDEPTH];
   logic [NW-1:0]       fail_mem  [NODES];
   logic [PATTERNS-1:0] out_mem   [NODES];
   logic [NW-1:0]       queue_mem [NODES];

   logic [NW-1:0]       child_q_ff, fail_q_ff, queue_q_ff;
   logic [PATTERNS-1:0] out_q_ff;

   // control state
   logic [4:0]          state_ff, state_in;
   logic [NW-1:0]       lc_ff, lc_in;
   logic [NW-1:0]       scan_ff, scan_in;
   logic [PATTERNS-1:0] seen_ff, seen_in;
   logic [CW-1:0]       nu_ff, nu_in;
   logic [PCW-1:0]      pu_ff, pu_in;
   logic [NW-1:0]       clr_row_ff, clr_row_in;
   logic [AW-1:0]       col_ff, col_in;
   logic                clr_init_ff, clr_init_in;
   logic [CW-1:0]       head_ff, head_in;
   logic [CW-1:0]       tail_ff, tail_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath state
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [AW-1:0]       let_ff, let_in;
   logic [NW-1:0]       t_ff, t_in;
   logic [NW-1:0]       u_ff, u_in;
   logic [NW-1:0]       c_ff, c_in;
   logic [NW-1:0]       f_ff, f_in;
   logic [PATTERNS-1:0] of_ff, of_in;
   logic [CW-1:0]       guard_ff, guard_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PATTERNS-1:0] match_ff, match_in;
   logic [PCW-1:0]      fresh_ff, fresh_in;

   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [NODE_OUT_W-1:0]  rsp_node_ff;
   logic [MASK_OUT_W-1:0]  rsp_match_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic [MASK_OUT_W-1:0]  rsp_seen_ff;
   logic                   rsp_load;

   // shared child table address unit and memory controls
   logic [NW-1:0]       ch_row;
   logic [AW-1:0]       ch_col;
   logic [CAW-1:0]      ch_addr;
   logic                ch_we;
   logic [NW-1:0]       ch_wd;
   logic [NW-1:0]       fail_ra, fail_wa, fail_wd;
   logic                fail_we;
   logic [NW-1:0]       out_ra, out_wa;
   logic [PATTERNS-1:0] out_wd;
   logic                out_we;
   logic [NW-1:0]       queue_ra, queue_wa, queue_wd;
   logic                queue_we;

   logic                req_fire;
   logic                letter_ok;
   logic [PATTERNS-1:0] fresh_bits;
   logic                last_col;
   logic [NW-1:0]       node_sel;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign letter_ok     = (32'(req_bus.letter) < ALPHABET);
   assign ch_addr       = CAW'(CAW'(ch_row) * CAW'(ALPHABET) + CAW'(ch_col));
   assign fresh_bits    = out_q_ff & ~seen_ff;
   assign last_col      = (col_ff == AW'(ALPHABET - 1));
   assign node_sel      = (cmd_ff == CMD_ADD || cmd_ff == CMD_END) ? lc_ff : scan_ff;
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      lc_in        = lc_ff;
      scan_in      = scan_ff;
      seen_in      = seen_ff;
      nu_in        = nu_ff;
      pu_in        = pu_ff;
      clr_row_in   = clr_row_ff;
      col_in       = col_ff;
      clr_init_in  = clr_init_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cmd_in       = cmd_ff;
      let_in       = let_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      c_in         = c_ff;
      f_in         = f_ff;
      of_in        = of_ff;
      guard_in     = guard_ff;
      status_in    = status_ff;
      match_in     = match_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff;

      ch_row   = '0;
      ch_col   = '0;
      ch_we    = 1'b0;
      ch_wd    = '0;
      fail_ra  = t_ff;
      fail_we  = 1'b0;
      fail_wa  = '0;
      fail_wd  = '0;
      out_ra   = f_ff;
      out_we   = 1'b0;
      out_wa   = '0;
      out_wd   = '0;
      queue_ra = NW'(head_ff);
      queue_we = 1'b0;
      queue_wa = '0;
      queue_wd = '0;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end

      unique case (state_ff)
         ST_CLR: begin
            ch_row = clr_row_ff;
            ch_col = col_ff;
            ch_we  = 1'b1;
            col_in = col_ff + AW'(1);
            if (last_col) begin
               col_in   = '0;
               state_in = clr_init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_bus.cmd;
               let_in    = AW'(req_bus.letter);
               status_in = STATUS_OK;
               match_in  = '0;
               fresh_in  = '0;
               state_in  = ST_DONE;
               unique case (req_bus.cmd)
                  CMD_ADD: begin
                     if (letter_ok) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  CMD_END: begin
                     if (32'(pu_ff) >= PATTERNS) begin
                        status_in = STATUS_PAT_FULL;
                     end else begin
                        out_we = 1'b1;
                        out_wa = lc_ff;
                        out_wd = PATTERNS'(1) << pu_ff;
                        pu_in  = pu_ff + PCW'(1);
                     end
                     lc_in = '0;
                  end
                  CMD_BUILD: begin
                     queue_we = 1'b1;
                     fail_we  = 1'b1;
                     head_in  = '0;
                     tail_in  = CW'(1);
                     state_in = ST_B_POP;
                  end
                  CMD_SCAN: begin
                     if (letter_ok) begin
                        t_in     = scan_ff;
                        guard_in = '0;
                        state_in = ST_S_RD;
                     end else begin
                        scan_in = '0;
                     end
                  end
                  CMD_RESTART: begin
                     scan_in = '0;
                     seen_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_RD: begin
            ch_row   = lc_ff;
            ch_col   = let_ff;
            state_in = ST_ADD_CHK;
         end
         ST_ADD_CHK: begin
            ch_row   = lc_ff;
            ch_col   = let_ff;
            state_in = ST_DONE;
            if (child_q_ff != '0) begin
               lc_in = child_q_ff;
            end else if (32'(nu_ff) >= NODES) begin
               status_in = STATUS_TRIE_FULL;
            end else begin
               ch_we       = 1'b1;
               ch_wd       = NW'(nu_ff);
               fail_we     = 1'b1;
               fail_wa     = NW'(nu_ff);
               out_we      = 1'b1;
               out_wa      = NW'(nu_ff);
               lc_in       = NW'(nu_ff);
               nu_in       = nu_ff + CW'(1);
               clr_row_in  = NW'(nu_ff);
               col_in      = '0;
               clr_init_in = 1'b0;
               state_in    = ST_CLR;
            end
         end
         ST_S_RD: begin
            ch_row   = t_ff;
            ch_col   = let_ff;
            state_in = ST_S_CHK;
         end
         ST_S_CHK: begin
            out_ra = child_q_ff;
            if (child_q_ff != '0) begin
               scan_in  = child_q_ff;
               state_in = ST_S_OUT;
            end else if (t_ff == '0 || 32'(guard_ff) >= NODES) begin
               scan_in  = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_S_FAIL;
            end
         end
         ST_S_FAIL: begin
            t_in     = fail_q_ff;
            guard_in = guard_ff + CW'(1);
            state_in = ST_S_RD;
         end
         ST_S_OUT: begin
            match_in = out_q_ff;
            fresh_in = PCW'($countones(fresh_bits));
            seen_in  = seen_ff | out_q_ff;
            state_in = ST_DONE;
         end
         ST_B_POP: begin
            if (head_ff < tail_ff) begin
               head_in  = head_ff + CW'(1);
               state_in = ST_B_U;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_B_U: begin
            u_in     = queue_q_ff;
            col_in   = '0;
            state_in = ST_B_C_RD;
         end
         ST_B_C_RD: begin
            ch_row   = u_ff;
            ch_col   = col_ff;
            state_in = ST_B_C_CHK;
         end
         ST_B_C_CHK: begin
            fail_ra = u_ff;
            c_in    = child_q_ff;
            if (child_q_ff == '0) begin
               state_in = ST_B_NEXT;
            end else if (u_ff == '0) begin
               f_in     = '0;
               state_in = ST_B_SET;
            end else begin
               guard_in = '0;
               state_in = ST_B_D;
            end
         end
         ST_B_D: begin
            t_in     = fail_q_ff;
            state_in = ST_B_W_RD;
         end
         ST_B_W_RD: begin
            ch_row   = t_ff;
            ch_col   = col_ff;
            state_in = ST_B_W_CHK;
         end
         ST_B_W_CHK: begin
            fail_ra = t_ff;
            if (t_ff != '0 && child_q_ff == '0 && 32'(guard_ff) < NODES) begin
               state_in = ST_B_WF;
            end else begin
               f_in     = child_q_ff;
               state_in = ST_B_SET;
            end
         end
         ST_B_WF: begin
            t_in     = fail_q_ff;
            guard_in = guard_ff + CW'(1);
            state_in = ST_B_W_RD;
         end
         ST_B_SET: begin
            fail_we = 1'b1;
            fail_wa = c_ff;
            fail_wd = f_ff;
            if (32'(tail_ff) < NODES) begin
               queue_we = 1'b1;
               queue_wa = NW'(tail_ff);
               queue_wd = c_ff;
               tail_in  = tail_ff + CW'(1);
            end
            state_in = (f_ff != '0) ? ST_B_M2 : ST_B_NEXT;
         end
         ST_B_M2: begin
            out_ra   = c_ff;
            of_in    = out_q_ff;
            state_in = ST_B_M3;
         end
         ST_B_M3: begin
            out_we   = 1'b1;
            out_wa   = c_ff;
            out_wd   = out_q_ff | of_ff;
            state_in = ST_B_NEXT;
         end
         ST_B_NEXT: begin
            if (last_col) begin
               state_in = ST_B_POP;
            end else begin
               col_in   = col_ff + AW'(1);
               state_in = ST_B_C_RD;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ch_we) begin
         child_mem[ch_addr] <= ch_wd;
      end
      child_q_ff <= child_mem[ch_addr];
      if (fail_we) begin
         fail_mem[fail_wa] <= fail_wd;
      end
      fail_q_ff <= fail_mem[fail_ra];
      if (out_we) begin
         out_mem[out_wa] <= out_wd;
      end
      out_q_ff <= out_mem[out_ra];
      if (queue_we) begin
         queue_mem[queue_wa] <= queue_wd;
      end
      queue_q_ff <= queue_mem[queue_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         lc_ff        <= '0;
         scan_ff      <= '0;
         seen_ff      <= '0;
         nu_ff        <= CW'(1);
         pu_ff        <= '0;
         clr_row_ff   <= '0;
         col_ff       <= '0;
         clr_init_ff  <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         scan_ff      <= scan_in;
         seen_ff      <= seen_in;
         nu_ff        <= nu_in;
         pu_ff        <= pu_in;
         clr_row_ff   <= clr_row_in;
         col_ff       <= col_in;
         clr_init_ff  <= clr_init_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      let_ff    <= let_in;
      t_ff      <= t_in;
      u_ff      <= u_in;
      c_ff      <= c_in;
      f_ff      <= f_in;
      of_ff     <= of_in;
      guard_ff  <= guard_in;
      status_ff <= status_in;
      match_ff  <= match_in;
      fresh_ff  <= fresh_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_node_ff   <= NODE_OUT_W'(node_sel);
         rsp_match_ff  <= MASK_OUT_W'(match_ff);
         rsp_count_ff  <= COUNT_OUT_W'(fresh_ff);
         rsp_seen_ff   <= MASK_OUT_W'(seen_ff);
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.node       = rsp_node_ff;
   assign rsp_bus.match_mask = rsp_match_ff;
   assign rsp_bus.new_count  = rsp_count_ff;
   assign rsp_bus.seen_mask  = rsp_seen_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request accepted while previous one in progress");

   a_nodes_in_range: assert property (@(posedge clock) disable iff (reset)
      (nu_ff >= CW'(1)) && (32'(nu_ff) <= NODES))
      else $error("node allocation count out of range");

   a_cursor_allocated: assert property (@(posedge clock) disable iff (reset)
      (CW'(lc_ff) < nu_ff) && (CW'(scan_ff) < nu_ff))
      else $error("cursor points at unallocated node");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff) && (32'(tail_ff) <= NODES))
      else $error("breadth-first queue pointers inconsistent");

   a_match_in_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((rsp_bus.match_mask & ~rsp_bus.seen_mask) == '0))
      else $error("matched pattern missing from seen mask");
`endif

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the automaton matcher end to end: trie loading, link builds and scans
// are predicted in the bench and every response is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import mpam_pkg::*;

   localparam int NODES    = 512;
   localparam int ALPHABET = 26;
   localparam int PATTERNS = 8;
   localparam int STALL_LIMIT = 400000;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [NODE_OUT_W-1:0]  node;
      logic [MASK_OUT_W-1:0]  match_mask;
      logic [COUNT_OUT_W-1:0] new_count;
      logic [MASK_OUT_W-1:0]  seen_mask;
   } rsp_t;

   logic clock = 1'b0;
   logic reset;
   bit   calm;
   int   errors = 0;
   int   idle_cycles = 0;

   mpam_req_if req_bus ();
   mpam_rsp_if rsp_bus ();

   multi_pattern_automaton_matcher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // automaton state as the bench sees it
   int   trie_child [NODES*ALPHABET];
   int   fail_link  [NODES];
   logic [7:0] out_mask [NODES];
   int   walk_queue [NODES];
   int   node_count;
   int   pattern_count;
   int   cursor;
   int   scan_at;
   logic [7:0] seen;

   rsp_t expected_rsps[$];

   function automatic int child_at(int n, int l);
      if (n >= NODES || l >= ALPHABET) return 0;
      return trie_child[n*ALPHABET + l];
   endfunction

   function automatic void build_links();
      int head, tail, u, c, f, d, guard;
      head = 0;
      tail = 0;
      walk_queue[tail++] = 0;
      fail_link[0] = 0;
      while (head < tail) begin
         u = walk_queue[head++];
         for (int i = 0; i < ALPHABET; i++) begin
            c = child_at(u, i);
            if (c == 0) continue;
            f = 0;
            if (u != 0) begin
               d = fail_link[u];
               guard = 0;
               while (d != 0 && child_at(d, i) == 0 && guard < NODES) begin
                  d = fail_link[d];
                  guard++;
               end
               f = child_at(d, i);
            end
            fail_link[c] = f;
            if (f != 0) out_mask[c] |= out_mask[f];
            if (tail < NODES) walk_queue[tail++] = c;
         end
      end
   endfunction

   function automatic rsp_t predict_rsp(logic [CMD_W-1:0] cmd, logic [LETTER_W-1:0] letter);
      rsp_t r;
      int   t, c, guard;
      logic [7:0] fresh;
      r = '0;
      r.node = NODE_OUT_W'(scan_at);
      case (cmd)
         CMD_ADD: begin
            if (letter < ALPHABET) begin
               c = child_at(cursor, letter);
               if (c != 0) cursor = c;
               else if (node_count >= NODES) r.status = STATUS_TRIE_FULL;
               else begin
                  trie_child[cursor*ALPHABET + letter] = node_count;
                  cursor = node_count;
                  node_count++;
               end
            end
            r.node = NODE_OUT_W'(cursor);
         end
         CMD_END: begin
            if (pattern_count >= PATTERNS) r.status = STATUS_PAT_FULL;
            else begin
               out_mask[cursor] = 8'(1 << pattern_count);
               pattern_count++;
            end
            cursor = 0;
            r.node = '0;
         end
         CMD_BUILD: build_links();
         CMD_SCAN: begin
            t = scan_at;
            guard = 0;
            forever begin
               c = child_at(t, letter);
               if (c != 0) begin
                  scan_at = c;
                  r.match_mask = out_mask[c];
                  break;
               end
               if (t == 0 || guard >= NODES) begin
                  scan_at = 0;
                  break;
               end
               t = fail_link[t];
               guard++;
            end
            fresh = r.match_mask & ~seen;
            r.new_count = COUNT_OUT_W'($countones(fresh));
            seen |= r.match_mask;
            r.node = NODE_OUT_W'(scan_at);
         end
         CMD_RESTART: begin
            scan_at = 0;
            seen = '0;
            r.node = '0;
         end
         default: ;
      endcase
      r.seen_mask = seen;
      return r;
   endfunction

   function automatic bit take_gap();
      return !calm && $urandom_range(99) < 28;
   endfunction

   task automatic send_req(logic [CMD_W-1:0] cmd, logic [LETTER_W-1:0] letter);
      @(negedge clock);
      while (take_gap()) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid  = 1'b1;
      req_bus.cmd    = cmd;
      req_bus.letter = letter;
      do @(posedge clock); while (!req_bus.ready);
      expected_rsps.push_back(predict_rsp(cmd, letter));
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic send_word(string s);
      foreach (s[i]) send_req(CMD_ADD, LETTER_W'(s[i] - "a"));
      send_req(CMD_END, '0);
   endtask

   task automatic scan_word(string s);
      foreach (s[i]) send_req(CMD_SCAN, LETTER_W'(s[i] - "a"));
   endtask

   task automatic test_directed();
      send_word("he");
      send_word("she");
      send_word("hers");
      send_req(CMD_END, '0);            // empty pattern lands on the root
      send_word("he");                  // repeat: newer bit replaces the old
      send_req(CMD_ADD, 5'd31);         // off-alphabet add is ignored
      send_req(3'd5, 5'd0);
      send_req(3'd6, 5'd31);
      send_req(3'd7, 5'd12);
      send_req(CMD_BUILD, '0);
      scan_word("ushers");
      send_req(CMD_SCAN, 5'd30);
      send_req(CMD_RESTART, '0);
   endtask

   function automatic logic [CMD_W-1:0] CMD_TYPE_NOISE();
      return CMD_W'($urandom_range(7));
   endfunction

   // mostly scans over a small letter set so matches are frequent
   task automatic random_traffic(int count);
      int k, len;
      k = 0;
      while (k < count) begin
         case ($urandom_range(99)) inside
            [0:59]: begin
               send_req(CMD_SCAN, $urandom_range(9) == 0 ? LETTER_W'($urandom_range(31))
                                                        : LETTER_W'($urandom_range(3)));
               k++;
            end
            [60:67]: begin
               send_req(CMD_RESTART, LETTER_W'($urandom_range(31)));
               k++;
            end
            [68:84]: begin
               len = $urandom_range(4);
               repeat (len) send_req(CMD_ADD, LETTER_W'($urandom_range(4)));
               if ($urandom_range(5) == 0) send_req(CMD_ADD, LETTER_W'($urandom_range(31)));
               send_req(CMD_END, LETTER_W'($urandom_range(31)));
               k += len + 1;
            end
            [85:90]: begin
               send_req(CMD_BUILD, LETTER_W'($urandom_range(31)));
               k++;
            end
            default: begin
               send_req(CMD_TYPE_NOISE(), LETTER_W'($urandom_range(31)));
               k++;
            end
         endcase
      end
   endtask

   task automatic test_pattern_overflow();
      repeat (5) send_req(CMD_END, LETTER_W'($urandom_range(31)));
      send_req(CMD_BUILD, '0);
      send_req(CMD_RESTART, '0);
   endtask

   task automatic test_trie_full();
      while (node_count < NODES) send_req(CMD_ADD, 5'd25);
      send_req(CMD_ADD, 5'd25);
      send_req(CMD_ADD, 5'd24);
      send_req(CMD_END, '0);
      send_req(CMD_BUILD, '0);
      send_req(CMD_RESTART, '0);
      repeat (12) send_req(CMD_SCAN, $urandom_range(1) ? 5'd25 : LETTER_W'($urandom_range(3)));
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_t got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.status, rsp_bus.node, rsp_bus.match_mask,
                 rsp_bus.new_count, rsp_bus.seen_mask};
         if (expected_rsps.size() == 0) begin
            $error("response with none expected: %p", got);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               errors++;
            end
            if (got.node !== want.node) begin
               $error("node: expected %0d, got %0d", want.node, got.node);
               errors++;
            end
            if (got.match_mask !== want.match_mask) begin
               $error("match_mask: expected %h, got %h", want.match_mask, got.match_mask);
               errors++;
            end
            if (got.new_count !== want.new_count) begin
               $error("new_count: expected %0d, got %0d", want.new_count, got.new_count);
               errors++;
            end
            if (got.seen_mask !== want.seen_mask) begin
               $error("seen_mask: expected %h, got %h", want.seen_mask, got.seen_mask);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready = calm || $urandom_range(99) >= 28;
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      req_bus.valid  = 1'b0;
      req_bus.cmd    = CMD_ADD;
      req_bus.letter = '0;
      reset = 1'b1;
      calm = 1'b0;
      foreach (trie_child[i]) trie_child[i] = 0;
      foreach (fail_link[i]) begin
         fail_link[i] = 0;
         out_mask[i]  = '0;
      end
      node_count = 1;
      pattern_count = 0;
      cursor = 0;
      scan_at = 0;
      seen = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // filling the trie needs close to NODES adds, so random traffic stays short
      test_directed();
      random_traffic(30);
      drain();
      calm = 1'b1;
      random_traffic(15);
      calm = 1'b0;
      test_pattern_overflow();
      random_traffic(15);
      test_trie_full();
      drain();

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
